// ===== sv/sfr_pkg.sv =====
// shared types, constants and the crc byte update for the stuffed frame receiver
package sfr_pkg;

  localparam int MAX_FRAME_BYTES = 128;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int EXT_W = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNESCAPE_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_REPLY_CODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE = 3'd5;

  localparam logic [1:0] PHASE_CMD = 2'd0;
  localparam logic [1:0] PHASE_ADDR_LO = 2'd1;
  localparam logic [1:0] PHASE_ADDR_HI = 2'd2;
  localparam logic [1:0] PHASE_DATA = 2'd3;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
    logic [7:0] unescape_mask;
    logic [7:0] read_reply_code;
    logic [7:0] ack_code;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        frame_ok;
    logic [7:0]  command;
    logic [15:0] address;
    logic [6:0]  data_count;
    logic        is_read_reply;
    logic        is_ack;
  } res_t;

  // one byte into a reflected crc-16, bit by bit
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/sfr_in_if.sv =====
// request channel carrying raw serial bytes
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sfr_out_if.sv =====
// result channel carrying data bytes and frame reports
interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic        frame_ok;
  logic [7:0]  command;
  logic [15:0] address;
  logic [6:0]  data_count;
  logic        is_read_reply;
  logic        is_ack;

  modport source (output valid, output kind, output data_byte, output frame_ok,
                  output command, output address, output data_count,
                  output is_read_reply, output is_ack, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_ok,
                input command, input address, input data_count,
                input is_read_reply, input is_ack, output ready);
endinterface

// ===== sv/stuffed_frame_receiver_crc16.sv =====
// top level of the byte stuffed frame receiver with crc-16 check
//
//   channel  direction  payload
//   in_if    in         rx_byte
//   out_if   out        kind, data_byte, frame_ok, command, address,
//                       data_count, is_read_reply, is_ack
//   cfg_*    in         cfg_we, cfg_idx, cfg_wdata (write only)
//
// one byte per cycle while the result is not stalled: input register, one pass of decode and crc, result register
// a byte passes the input register and then the result register before its result is valid
// crc update is an eight step unrolled shift per byte in the decode pass
// synchronous active low reset clears frame state, config and both valid flags
// a stalled result holds its register; one more request is buffered behind it
module stuffed_frame_receiver_crc16 (
  input  logic                          clk,
  input  logic                          rst_n,
  sfr_in_if.sink                        in_if,
  sfr_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]                    cfg_wdata
);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::res_t res;
  sfr_pkg::res_t out_data_r;
  logic          res_valid;
  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  logic          out_valid_r;
  logic          adv;
  logic          fire;
  logic          in_take;

  assign adv     = !out_valid_r || out_if.ready;
  assign fire    = in_valid_r && adv;
  assign in_take = in_if.valid && in_if.ready;
  assign in_if.ready = !in_valid_r || adv;

  sfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sfr_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rx_byte   (in_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= (in_valid_r && !adv) || in_take;
      if (adv) begin
        out_valid_r <= fire && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_if.rx_byte;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.kind          = out_data_r.kind;
  assign out_if.data_byte     = out_data_r.data_byte;
  assign out_if.frame_ok      = out_data_r.frame_ok;
  assign out_if.command       = out_data_r.command;
  assign out_if.address       = out_data_r.address;
  assign out_if.data_count    = out_data_r.data_count;
  assign out_if.is_read_reply = out_data_r.is_read_reply;
  assign out_if.is_ack        = out_data_r.is_ack;

endmodule

// ===== sv/sfr_cfg_regs.sv =====
// configuration register file of the frame receiver
module sfr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]                    cfg_wdata,
  output sfr_pkg::cfg_t                 cfg
);

  sfr_pkg::cfg_t cfg_r;
  sfr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        sfr_pkg::CFG_START_BYTE:      cfg_nxt.start_byte = cfg_wdata;
        sfr_pkg::CFG_END_BYTE:        cfg_nxt.end_byte = cfg_wdata;
        sfr_pkg::CFG_ESCAPE_BYTE:     cfg_nxt.escape_byte = cfg_wdata;
        sfr_pkg::CFG_UNESCAPE_MASK:   cfg_nxt.unescape_mask = cfg_wdata;
        sfr_pkg::CFG_READ_REPLY_CODE: cfg_nxt.read_reply_code = cfg_wdata;
        sfr_pkg::CFG_ACK_CODE:        cfg_nxt.ack_code = cfg_wdata;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/sfr_frame.sv =====
// frame state: unescaping, header capture, crc delay line, data bytes and frame report
module sfr_frame (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    rx_byte,
  input  sfr_pkg::cfg_t cfg,
  output logic          res_valid,
  output sfr_pkg::res_t res
);

  logic                      in_frame_r, in_frame_nxt;
  logic                      esc_r, esc_nxt;
  logic [1:0]                phase_r, phase_nxt;
  logic [sfr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [15:0]               crc_r, crc_nxt;
  logic [7:0]                tail0_r, tail0_nxt;
  logic [7:0]                tail1_r, tail1_nxt;
  logic [7:0]                cmd_r, cmd_nxt;
  logic [15:0]               addr_r, addr_nxt;

  logic                      do_store;
  logic [7:0]                st_byte;
  logic                      long_enough;
  logic                      ok;
  logic [sfr_pkg::EXT_W-1:0] diff;
  logic [6:0]                cnt_sat;

  assign long_enough = (count_r >= sfr_pkg::CNT_W'(5));
  assign ok = long_enough && (tail0_r == crc_r[15:8]) && (tail1_r == crc_r[7:0]);
  assign diff = sfr_pkg::EXT_W'(count_r) - sfr_pkg::EXT_W'(5);
  assign cnt_sat = !long_enough ? 7'd0 :
                   (diff > sfr_pkg::EXT_W'(127)) ? 7'd127 : diff[6:0];

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    tail0_nxt    = tail0_r;
    tail1_nxt    = tail1_r;
    cmd_nxt      = cmd_r;
    addr_nxt     = addr_r;
    res_valid    = 1'b0;
    res          = '0;
    do_store     = 1'b0;
    st_byte      = rx_byte;

    if (fire) begin
      if (rx_byte == cfg.start_byte) begin
        // start always wins and clears the frame
        in_frame_nxt = 1'b1;
        esc_nxt      = 1'b0;
        phase_nxt    = sfr_pkg::PHASE_CMD;
        count_nxt    = '0;
        crc_nxt      = sfr_pkg::CRC_INIT;
        tail0_nxt    = '0;
        tail1_nxt    = '0;
        cmd_nxt      = '0;
        addr_nxt     = '0;
      end else if (rx_byte == cfg.end_byte) begin
        if (in_frame_r) begin
          res_valid         = 1'b1;
          res.kind          = sfr_pkg::KIND_REPORT;
          res.frame_ok      = ok;
          res.command       = cmd_r;
          res.address       = addr_r;
          res.data_count    = cnt_sat;
          res.is_read_reply = ok && (cmd_r == cfg.read_reply_code);
          res.is_ack        = ok && (cmd_r == cfg.ack_code);
          in_frame_nxt      = 1'b0;
          esc_nxt           = 1'b0;
        end
      end else if (in_frame_r) begin
        if (esc_r) begin
          esc_nxt  = 1'b0;
          do_store = 1'b1;
          st_byte  = rx_byte ^ cfg.unescape_mask;
        end else if (rx_byte == cfg.escape_byte) begin
          esc_nxt = 1'b1;
        end else begin
          do_store = 1'b1;
        end
      end
    end

    if (do_store && (count_r < sfr_pkg::CNT_W'(sfr_pkg::MAX_FRAME_BYTES))) begin
      case (phase_r)
        sfr_pkg::PHASE_CMD: begin
          cmd_nxt   = st_byte;
          phase_nxt = sfr_pkg::PHASE_ADDR_LO;
        end
        sfr_pkg::PHASE_ADDR_LO: begin
          addr_nxt  = {addr_r[15:8], st_byte};
          phase_nxt = sfr_pkg::PHASE_ADDR_HI;
        end
        sfr_pkg::PHASE_ADDR_HI: begin
          addr_nxt  = {st_byte, addr_r[7:0]};
          phase_nxt = sfr_pkg::PHASE_DATA;
        end
        default: phase_nxt = phase_r;
      endcase
      // byte leaving the delay line can no longer be crc
      if (count_r >= sfr_pkg::CNT_W'(2)) begin
        crc_nxt = sfr_pkg::crc_feed(crc_r, tail0_r);
        if (long_enough) begin
          res_valid     = 1'b1;
          res.kind      = sfr_pkg::KIND_DATA;
          res.data_byte = tail0_r;
        end
      end
      tail0_nxt = tail1_r;
      tail1_nxt = st_byte;
      count_nxt = count_r + sfr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      phase_r    <= sfr_pkg::PHASE_CMD;
      count_r    <= '0;
      crc_r      <= sfr_pkg::CRC_INIT;
      tail0_r    <= '0;
      tail1_r    <= '0;
      cmd_r      <= '0;
      addr_r     <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      crc_r      <= crc_nxt;
      tail0_r    <= tail0_nxt;
      tail1_r    <= tail1_nxt;
      cmd_r      <= cmd_nxt;
      addr_r     <= addr_nxt;
    end
  end

endmodule
